FILE: rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// shared constants, payload structs and controller/datapath command types
// ----------------------------------------------------------------------------
package rc4_pkg;

   // key store depth and address width
   localparam int KEY_DEPTH = 256;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   // permutation table
   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = 8;

   // key length register
   localparam int                LEN_W         = 9;
   localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(16);

   // request modes
   localparam logic [1:0] MODE_KEY_WRITE = 2'd0;
   localparam logic [1:0] MODE_SCHEDULE  = 2'd1;
   localparam logic [1:0] MODE_STREAM    = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] key_position;
      logic [7:0] key_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       is_keystream;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_W1,
      ST_KS_W2,
      ST_GEN_RJ,
      ST_GEN_W1,
      ST_GEN_W2
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_KEY_WR,
      OP_ACK,
      OP_SCHED_INIT,
      OP_FILL,
      OP_KS_RD,
      OP_KS_J,
      OP_KS_W1,
      OP_KS_W2,
      OP_GEN_RI,
      OP_GEN_RJ,
      OP_GEN_W1,
      OP_GEN_W2
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last_pos;
   } dp_status_type;

endpackage

FILE: rtl/core/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// datapath: permutation and key memories, indices, swap and result register
// ----------------------------------------------------------------------------
module rc4_dp
   import rc4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_item,
   input  dp_cmd_type       cmd,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   output dp_status_type    status,
   output logic             rsp_strobe,
   output rsp_type          rsp_item
);

   logic [7:0] perm_mem [PERM_SIZE];
   logic [7:0] key_mem  [KEY_DEPTH];

   logic [LEN_W-1:0]   key_size_ff;
   logic [PERM_AW-1:0] i_ff, i_in;
   logic [PERM_AW-1:0] j_ff, j_in;
   logic [PERM_AW-1:0] p_ff, p_in;
   logic [PERM_AW-1:0] q_ff, q_in;
   logic [KEY_AW-1:0]  k_ff, k_in;
   logic [7:0]         a_ff, a_in;
   logic [7:0]         b_ff, b_in;
   logic [PERM_AW-1:0] t_ff, t_in;
   logic [7:0]         rd_a_ff, rd_b_ff, key_rd_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic [PERM_AW-1:0] pa_addr, pb_addr, pw_addr;
   logic [7:0]         pw_data;
   logic               pw_en, kw_en;
   logic [LEN_W-1:0]   eff_len;
   logic               k_wrap;
   logic [7:0]         fwd_byte;

   // key length 0 acts as 1, above the store depth saturates
   always_comb begin
      if (key_size_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (key_size_ff > LEN_W'(KEY_DEPTH)) begin
         eff_len = LEN_W'(KEY_DEPTH);
      end else begin
         eff_len = key_size_ff;
      end
   end

   assign k_wrap = (LEN_W'(k_ff) + LEN_W'(1)) == eff_len;

   // final read sees the swap: last write (index j) wins
   always_comb begin
      if (t_ff == j_ff) begin
         fwd_byte = a_ff;
      end else if (t_ff == i_ff) begin
         fwd_byte = b_ff;
      end else begin
         fwd_byte = rd_a_ff;
      end
   end

   always_comb begin
      i_in          = i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      k_in          = k_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      t_in          = t_ff;
      pa_addr       = p_ff;
      pb_addr       = q_ff;
      pw_en         = 1'b0;
      pw_addr       = p_ff;
      pw_data       = rd_b_ff;
      kw_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      unique case (cmd.op)
         OP_KEY_WR: begin
            kw_en         = (LEN_W'(req_item.key_position) < LEN_W'(KEY_DEPTH));
            rsp_strobe_in = 1'b1;
            rsp_item_in   = '0;
         end
         OP_ACK: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in   = '0;
         end
         OP_SCHED_INIT: begin
            p_in = '0;
            q_in = '0;
            k_in = '0;
         end
         OP_FILL: begin
            pw_en   = 1'b1;
            pw_addr = p_ff;
            pw_data = 8'(p_ff);
            p_in    = p_ff + 1'b1;
         end
         OP_KS_RD: begin
            pa_addr = p_ff;
         end
         OP_KS_J: begin
            q_in    = q_ff + key_rd_ff + rd_a_ff;
            pb_addr = q_in;
            a_in    = rd_a_ff;
         end
         OP_KS_W1: begin
            pw_en   = 1'b1;
            pw_addr = p_ff;
            pw_data = rd_b_ff;
         end
         OP_KS_W2: begin
            pw_en   = 1'b1;
            pw_addr = q_ff;
            pw_data = a_ff;
            p_in    = p_ff + 1'b1;
            k_in    = k_wrap ? '0 : k_ff + 1'b1;
            if (status.last_pos) begin
               i_in          = '0;
               j_in          = '0;
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '0;
            end
         end
         OP_GEN_RI: begin
            i_in    = i_ff + 1'b1;
            pa_addr = i_in;
         end
         OP_GEN_RJ: begin
            j_in    = j_ff + rd_a_ff;
            pb_addr = j_in;
            a_in    = rd_a_ff;
         end
         OP_GEN_W1: begin
            pw_en   = 1'b1;
            pw_addr = i_ff;
            pw_data = rd_b_ff;
            b_in    = rd_b_ff;
            t_in    = a_ff + rd_b_ff;
            pa_addr = t_in;
         end
         OP_GEN_W2: begin
            pw_en                    = 1'b1;
            pw_addr                  = j_ff;
            pw_data                  = a_ff;
            rsp_strobe_in            = 1'b1;
            rsp_item_in.stream_byte  = fwd_byte;
            rsp_item_in.is_keystream = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign status.last_pos = (p_ff == PERM_AW'(PERM_SIZE - 1));

   // permutation memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (pw_en) begin
         perm_mem[pw_addr] <= pw_data;
      end
      rd_a_ff <= perm_mem[pa_addr];
      rd_b_ff <= perm_mem[pb_addr];
   end

   // key memory: written from the request, read at the schedule key index
   always_ff @(posedge clock) begin
      if (kw_en) begin
         key_mem[req_item.key_position[KEY_AW-1:0]] <= req_item.key_byte;
      end
      key_rd_ff <= key_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff   <= KEY_LEN_RESET;
         i_ff          <= '0;
         j_ff          <= '0;
         p_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            key_size_ff <= csr_wdata;
         end
         i_ff          <= i_in;
         j_ff          <= j_in;
         p_ff          <= p_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      t_ff        <= t_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: rtl/core/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// sequencer for key write, key schedule and keystream step
// ----------------------------------------------------------------------------
module rc4_ctrl
   import rc4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    mode,
   input  dp_status_type status,
   output logic          busy,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (mode)
                  MODE_KEY_WRITE: begin
                     cmd.op = OP_KEY_WR;
                  end
                  MODE_SCHEDULE: begin
                     cmd.op   = OP_SCHED_INIT;
                     state_in = ST_FILL;
                  end
                  MODE_STREAM: begin
                     cmd.op   = OP_GEN_RI;
                     state_in = ST_GEN_RJ;
                  end
                  default: begin
                     cmd.op = OP_ACK;
                  end
               endcase
            end
         end
         ST_FILL: begin
            cmd.op = OP_FILL;
            if (status.last_pos) begin
               state_in = ST_KS_RD;
            end
         end
         ST_KS_RD: begin
            cmd.op   = OP_KS_RD;
            state_in = ST_KS_J;
         end
         ST_KS_J: begin
            cmd.op   = OP_KS_J;
            state_in = ST_KS_W1;
         end
         ST_KS_W1: begin
            cmd.op   = OP_KS_W1;
            state_in = ST_KS_W2;
         end
         ST_KS_W2: begin
            cmd.op   = OP_KS_W2;
            state_in = status.last_pos ? ST_IDLE : ST_KS_RD;
         end
         ST_GEN_RJ: begin
            cmd.op   = OP_GEN_RJ;
            state_in = ST_GEN_W1;
         end
         ST_GEN_W1: begin
            cmd.op   = OP_GEN_W1;
            state_in = ST_GEN_W2;
         end
         ST_GEN_W2: begin
            cmd.op   = OP_GEN_W2;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/rc4_keystream_generator.sv
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// rc4 key store, key schedule and keystream generator with command interface
// ----------------------------------------------------------------------------
//
//   channel   ports                          transfer
//   -------   ----------------------------   ---------------------------------
//   request   start, busy, req_item          start high and busy low
//   result    rsp_strobe, rsp_item           rsp_strobe high, one cycle only
//   csr       csr_we, csr_wdata (key size)   csr_we high
//
// key write and unused mode: result in the cycle after the transfer, busy stays low
// keystream byte: busy through GEN_RJ, GEN_W1 and GEN_W2, result registered after
//   GEN_W2, so no new request transfers before then; the step sequence is set by
//   the single permutation write port (two swap writes) behind two dependent reads
// key schedule: busy for a 256-entry identity fill and 256 four-state swap steps
// synchronous reset clears i, j, p and the controller and sets key_len to 16; the
//   permutation and key memories keep their contents
// results cannot be stalled; a new request may transfer while a result shows
//
module rc4_keystream_generator
   import rc4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   // result channel
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   // key length register
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: decodes the mode and steps the datapath
   rc4_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .mode   (req_item.mode),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // memories, indices and registered result
   rc4_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // keystream request answers with a keystream byte after the swap sequence
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_STREAM)
         |-> ##4 (rsp_strobe && rsp_item.is_keystream))
      else $error("keystream result missing after request");

   // key write is acknowledged in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_KEY_WRITE)
         |=> (rsp_strobe && !rsp_item.is_keystream))
      else $error("key write acknowledgement missing");

   // acknowledgements carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.is_keystream) |-> (rsp_item.stream_byte == 8'd0))
      else $error("acknowledgement with nonzero byte");

   // every multi-cycle command ends with its result
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a result");

endmodule

FILE: tb/rc4_keystream_checker.sv
// ----------------------------------------------------------------------------
// rc4_keystream_checker
// watches the request, result and csr channels, predicts every result and
// compares it field by field; hands the failure count to the testbench top
// ----------------------------------------------------------------------------
module rc4_keystream_checker
   import rc4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_item,
   input  logic             rsp_strobe,
   input  rsp_type          rsp_item,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               rsp_outstanding
);

   // predicted block state
   logic [7:0]       perm_copy [PERM_SIZE];
   logic [7:0]       key_copy  [KEY_DEPTH];
   logic [7:0]       gen_i;
   logic [7:0]       gen_j;
   logic [LEN_W-1:0] key_len;

   rsp_type          pending_rsp [$];
   rsp_type          oldest_rsp;

   function automatic int used_key_len();
      int n;
      n = int'(key_len);
      if (n == 0) n = 1;
      if (n > KEY_DEPTH) n = KEY_DEPTH;
      return n;
   endfunction

   function automatic void run_key_schedule();
      int         n;
      logic [7:0] q;
      logic [7:0] t;
      n = used_key_len();
      q = 8'd0;
      for (int p = 0; p < PERM_SIZE; p++) perm_copy[p] = 8'(p);
      for (int p = 0; p < PERM_SIZE; p++) begin
         q = q + key_copy[p % n] + perm_copy[p];
         t = perm_copy[p];
         perm_copy[p] = perm_copy[q];
         perm_copy[q] = t;
      end
      gen_i = 8'd0;
      gen_j = 8'd0;
   endfunction

   function automatic logic [7:0] next_stream_byte();
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] sum;
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + perm_copy[gen_i];
      a = perm_copy[gen_i];
      b = perm_copy[gen_j];
      perm_copy[gen_i] = b;
      perm_copy[gen_j] = a;
      sum = a + b;
      return perm_copy[sum];
   endfunction

   function automatic rsp_type predict_result(req_type it);
      rsp_type r;
      r = '0;
      case (it.mode)
         MODE_KEY_WRITE: begin
            if (int'(it.key_position) < KEY_DEPTH) key_copy[it.key_position] = it.key_byte;
         end
         MODE_SCHEDULE: begin
            run_key_schedule();
         end
         MODE_STREAM: begin
            r.stream_byte  = next_stream_byte();
            r.is_keystream = 1'b1;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected byte %02h keystream %0b, got byte %02h keystream %0b",
                  what, want.stream_byte, want.is_keystream, got.stream_byte, got.is_keystream);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gen_i   = 8'd0;
         gen_j   = 8'd0;
         key_len = KEY_LEN_RESET;
         pending_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_item);
            end else begin
               oldest_rsp = pending_rsp.pop_front();
               if (oldest_rsp.stream_byte !== rsp_item.stream_byte ||
                   oldest_rsp.is_keystream !== rsp_item.is_keystream)
                  note_mismatch("field", oldest_rsp, rsp_item);
            end
         end
         if (csr_we) key_len = csr_wdata;
         if (start && !busy) pending_rsp.push_back(predict_result(req_item));
      end
      rsp_outstanding <= pending_rsp.size();
   end

endmodule

FILE: tb/tb_rc4_keystream_generator.sv
// ----------------------------------------------------------------------------
// tb_rc4_keystream_generator
// drives key writes, key schedules and keystream requests with random gaps,
// sweeps the key length register through its extremes and gives the verdict
// ----------------------------------------------------------------------------
module tb_rc4_keystream_generator;
   import rc4_pkg::*;

   // mode 3 has no name in the package; the block just acknowledges it
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   localparam int         RANDOM_ITEMS  = 700;
   localparam int         CALM_TAIL     = 100;   // last transfers go without gaps
   localparam int         SETTLE_CYCLES = 8;     // settle wait for a late keystream byte
   localparam int         IDLE_LIMIT    = 8000;  // longer than a schedule keeps busy high

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_item  = '0;
   logic             csr_we    = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;
   logic             busy;
   logic             rsp_strobe;
   rsp_type          rsp_item;

   int               mismatch_count;
   int               rsp_outstanding;

   // which key bytes hold a written value; a schedule must only read those
   bit               key_loaded [KEY_DEPTH];
   logic [LEN_W-1:0] key_len_now = KEY_LEN_RESET;
   int               sent_items;
   bit               gaps_on;
   int               quiet_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rc4_keystream_generator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   rc4_keystream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .rsp_outstanding (rsp_outstanding)
   );

   // watchdog: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_item(logic [1:0] m, logic [7:0] pos, logic [7:0] kb);
      req_type it;
      it.mode         = m;
      it.key_position = pos;
      it.key_byte     = kb;
      return it;
   endfunction

   // fields other than the mode are random when the mode ignores them
   function automatic req_type bare_item(logic [1:0] m);
      return make_item(m, 8'($urandom), 8'($urandom));
   endfunction

   function automatic int used_len(logic [LEN_W-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) n = 1;
      if (n > KEY_DEPTH) n = KEY_DEPTH;
      return n;
   endfunction

   // start stays high after the transfer so back-to-back items need no extra edge
   task automatic send(req_type it);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      if (it.mode == MODE_KEY_WRITE) key_loaded[it.key_position] = 1'b1;
      if (it.mode != MODE_UNUSED) sent_items++;
   endtask

   // random idle burst on the request side, none in the calm tail
   task automatic gap();
      if (gaps_on && sent_items < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // block idle: nothing expected, then a few cycles for a late result
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (rsp_outstanding != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_len(logic [LEN_W-1:0] v);
      csr_we      <= 1'b1;
      csr_wdata   <= v;
      key_len_now  = v;
      @(posedge clock);
      csr_we      <= 1'b0;
   endtask

   // every byte the schedule reads gets written; a few early ones get fresh values
   task automatic load_key();
      int n;
      n = used_len(key_len_now);
      for (int p = 0; p < n; p++) begin
         if (!key_loaded[p] || (p < 32 && $urandom_range(0, 3) == 0)) begin
            send(make_item(MODE_KEY_WRITE, 8'(p), 8'($urandom)));
            gap();
         end
      end
   endtask

   // a schedule followed by keystream bytes, mixed with key writes, unused modes and further schedules
   task automatic keystream_burst();
      int count;
      int pick;
      count = $urandom_range(8, 48);
      send(bare_item(MODE_SCHEDULE));
      gap();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send(make_item(MODE_KEY_WRITE, 8'($urandom), 8'($urandom)));
         else if (pick < 15)
            send(bare_item(MODE_UNUSED));
         else if (pick < 17)
            send(bare_item(MODE_SCHEDULE));
         else
            send(bare_item(MODE_STREAM));
         gap();
      end
   endtask

   initial begin
      logic [LEN_W-1:0] len_pick;
      int               phase;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: unused mode before any schedule, key byte extremes,
      // the top key position, then a schedule at the reset key length
      gaps_on = 1'b1;
      send(make_item(MODE_UNUSED, 8'hFF, 8'hFF));
      for (int p = 0; p < 16; p++)
         send(make_item(MODE_KEY_WRITE, 8'(p),
                        (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom)));
      send(make_item(MODE_KEY_WRITE, 8'hFF, 8'h5A));
      gap();
      send(bare_item(MODE_SCHEDULE));
      repeat (4) begin
         send(bare_item(MODE_STREAM));
         gap();
      end
      send(make_item(MODE_UNUSED, 8'h00, 8'h00));
      send(make_item(MODE_KEY_WRITE, 8'h00, 8'h00));

      // random part: each phase sets a key length while idle, loads the key,
      // runs the schedule and pulls keystream; first phases hit the extremes
      sent_items = 0;
      phase      = 0;
      while (sent_items < RANDOM_ITEMS) begin
         quiesce();
         case (phase)
            0:       len_pick = '0;          // zero acts as one
            1:       len_pick = '1;          // saturates at the store depth
            2:       len_pick = LEN_W'(1);
            3:       len_pick = LEN_W'(KEY_DEPTH);
            default: begin
               if ($urandom_range(0, 99) < 85)
                  len_pick = LEN_W'($urandom_range(1, 32));
               else
                  len_pick = LEN_W'($urandom_range(0, 511));
            end
         endcase
         write_key_len(len_pick);
         gaps_on = ($urandom_range(0, 3) != 0);
         load_key();
         keystream_burst();
         phase++;
      end

      quiesce();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_dp.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_keystream_generator.sv
tb/rc4_keystream_checker.sv
tb/tb_rc4_keystream_generator.sv
